// ----- rtl/pasev_pkg.sv -----
package pasev_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_CLOSE = 8'h29;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;
    localparam logic [1:0] ST_UNCLOSED  = 2'd3;

    typedef enum logic [2:0] {
        K_DIGIT = 3'd0,
        K_PLUS  = 3'd1,
        K_MINUS = 3'd2,
        K_OPEN  = 3'd3,
        K_CLOSE = 3'd4,
        K_OTHER = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [DIGIT_W-1:0]  digit;
        logic                last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/pasev_front.sv -----
module pasev_front
    import pasev_pkg::*;
(
    input  logic [CHAR_W-1:0] char_code,
    input  logic              last_char,
    output item_t             item
);

    logic [CHAR_W-1:0] offset;

    assign offset = char_code - CHAR_ZERO;

    always_comb begin
        item.digit = offset[DIGIT_W-1:0];
        item.last  = last_char;
        priority if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
            item.kind = K_DIGIT;
        end else if (char_code == CHAR_PLUS) begin
            item.kind = K_PLUS;
        end else if (char_code == CHAR_MINUS) begin
            item.kind = K_MINUS;
        end else if (char_code == CHAR_OPEN) begin
            item.kind = K_OPEN;
        end else if (char_code == CHAR_CLOSE) begin
            item.kind = K_CLOSE;
        end else begin
            item.kind = K_OTHER;
        end
    end

endmodule

// ----- rtl/pasev_queue.sv -----
module pasev_queue
    import pasev_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head,
    output q_stat_t stat
);

    item_t              q_mem [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/pasev_back.sv -----
module pasev_back
    import pasev_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  item_t              head,
    input  logic               head_valid,
    output logic               step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] out_value,
    output logic [1:0]         out_status
);

    logic [VALUE_W-1:0]   sum_reg, sum_next;
    logic                 sign_reg, sign_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 in_num_reg, in_num_next;
    logic [LVL_W-1:0]     level_reg, level_next;
    logic [1:0]           err_reg, err_next;
    logic [VALUE_W-1:0]   stk_sum_reg [STACK_DEPTH];
    logic                 stk_sign_reg [STACK_DEPTH];
    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic [1:0]           out_status_reg;

    logic [VALUE_W-1:0]   cls_sum;
    logic                 cls_sign;
    logic                 push_en;
    logic [STK_IDX_W-1:0] push_idx;
    logic [STK_IDX_W-1:0] pop_idx;
    logic [VALUE_W-1:0]   fin_sum;
    logic [1:0]           fin_err;

    assign step       = head_valid && (!head.last || !out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign push_idx   = level_reg[STK_IDX_W-1:0];
    assign pop_idx    = STK_IDX_W'(level_reg - 1'b1);

    always_comb begin
        if (in_num_reg) begin
            cls_sum  = sign_reg ? (sum_reg - acc_reg) : (sum_reg + acc_reg);
            cls_sign = 1'b0;
        end else begin
            cls_sum  = sum_reg;
            cls_sign = sign_reg;
        end

        sum_next    = cls_sum;
        sign_next   = cls_sign;
        acc_next    = '0;
        in_num_next = 1'b0;
        level_next  = level_reg;
        err_next    = err_reg;
        push_en     = 1'b0;

        unique case (head.kind)
            K_DIGIT: begin
                sum_next    = sum_reg;
                sign_next   = sign_reg;
                acc_next    = {acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0}
                              + VALUE_W'(head.digit);
                in_num_next = 1'b1;
            end
            K_PLUS: begin
                sign_next = 1'b0;
            end
            K_MINUS: begin
                sign_next = 1'b1;
            end
            K_OPEN: begin
                if (level_reg < LVL_W'(STACK_DEPTH)) begin
                    push_en    = 1'b1;
                    level_next = level_reg + 1'b1;
                end else if (err_reg == ST_OK) begin
                    err_next = ST_OVERFLOW;
                end
                sum_next  = '0;
                sign_next = 1'b0;
            end
            K_CLOSE: begin
                if (level_reg != '0) begin
                    level_next = level_reg - 1'b1;
                    sum_next   = stk_sign_reg[pop_idx] ? (stk_sum_reg[pop_idx] - cls_sum)
                                                       : (stk_sum_reg[pop_idx] + cls_sum);
                end else if (err_reg == ST_OK) begin
                    err_next = ST_UNMATCHED;
                end
            end
            K_OTHER: begin
            end
            default: begin
            end
        endcase

        if (in_num_next) begin
            fin_sum = sign_next ? (sum_next - acc_next) : (sum_next + acc_next);
        end else begin
            fin_sum = sum_next;
        end
        fin_err = (err_next == ST_OK && level_next != '0) ? ST_UNCLOSED : err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            sign_reg      <= 1'b0;
            acc_reg       <= '0;
            in_num_reg    <= 1'b0;
            level_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                if (head.last) begin
                    sum_reg    <= '0;
                    sign_reg   <= 1'b0;
                    acc_reg    <= '0;
                    in_num_reg <= 1'b0;
                    level_reg  <= '0;
                    err_reg    <= ST_OK;
                end else begin
                    sum_reg    <= sum_next;
                    sign_reg   <= sign_next;
                    acc_reg    <= acc_next;
                    in_num_reg <= in_num_next;
                    level_reg  <= level_next;
                    err_reg    <= err_next;
                end
            end
            if (step && head.last) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step && head.last) begin
            out_value_reg  <= fin_sum;
            out_status_reg <= fin_err;
        end
        if (step && push_en) begin
            stk_sum_reg[push_idx]  <= cls_sum;
            stk_sign_reg[push_idx] <= cls_sign;
        end
    end

endmodule

// ----- rtl/paren_add_sub_evaluator.sv -----
// Result: a beat marked last is accepted into the queue, and executing it from the queue head
// sets the m_tvalid register, given an empty queue and a free output register.
// Throughput: one character beat per cycle, as the executor updates sum, sign, accumulator
// and stack top together for each beat; a beat marked last waits while the previous result is held.
// Reset: synchronous, active-low aresetn clears the queue, the evaluator state and
// the output valid flag; output value, status and parenthesis stack contents are not cleared.
module paren_add_sub_evaluator
    import pasev_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [VALUE_W-1:0]  m_tdata,   // [31:0] value
    output logic [1:0]          m_tuser    // [1:0] status
);

    item_t   front_item;
    item_t   head;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    pasev_front u_front (
        .char_code (s_tdata),
        .last_char (s_tlast),
        .item      (front_item)
    );

    pasev_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    pasev_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_stat.empty),
        .step       (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata),
        .out_status (m_tuser)
    );

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("Executor consumed a beat from an empty queue.");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("Character beat written into a full queue.");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(pop && head.last))
        else $error("Result beat appeared without a final character being executed.");

endmodule

// ----- verif/paren_add_sub_evaluator_test.sv -----
`timescale 1ns / 100ps

module paren_add_sub_evaluator_test;
    import pasev_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_CHARS   = 1300;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } result_t;

    typedef struct {
        logic [CHAR_W-1:0]  code;
        logic               last;
        int                 reps;
        logic               typed;
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [VALUE_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    paren_add_sub_evaluator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Evaluator state as predicted.
    logic [VALUE_W-1:0] calc_sum;
    logic [VALUE_W-1:0] calc_accum;
    logic               calc_neg;
    logic               calc_in_num;
    logic [VALUE_W-1:0] calc_saved_sum [STACK_DEPTH];
    logic               calc_saved_neg [STACK_DEPTH];
    int unsigned        calc_level;
    logic [1:0]         calc_status;

    result_t           pending_results [$];
    logic [CHAR_W-1:0] expr_text [$];

    int  mismatch_count;
    int  results_checked;
    int  status_seen [4];
    int  expressions;
    int  meaningful_sent;
    int  stall_cycles;
    int  result_wait;
    bit  sink_burst;
    bit  source_burst;
    bit  drained_once;

    dir_row_t directed_rows [7] = '{
        '{CHAR_CLOSE, 1'b1, 1,  1'b1, 32'd0,          ST_UNMATCHED},
        '{CHAR_OPEN,  1'b1, 1,  1'b1, 32'd0,          ST_UNCLOSED},
        '{8'h00,      1'b1, 1,  1'b1, 32'd0,          ST_OK},
        '{CHAR_MINUS, 1'b0, 2,  1'b0, 32'd0,          ST_OK},
        '{8'h37,      1'b1, 1,  1'b1, 32'hFFFF_FFF9,  ST_OK},
        '{CHAR_OPEN,  1'b1, 17, 1'b1, 32'd0,          ST_OVERFLOW},
        '{8'hFF,      1'b1, 1,  1'b1, 32'd0,          ST_OK}
    };

    task automatic clear_calc();
        calc_sum    = '0;
        calc_accum  = '0;
        calc_neg    = 1'b0;
        calc_in_num = 1'b0;
        calc_level  = 0;
        calc_status = ST_OK;
    endtask

    task automatic fold_number();
        if (calc_in_num) begin
            calc_sum    = calc_neg ? calc_sum - calc_accum : calc_sum + calc_accum;
            calc_accum  = '0;
            calc_in_num = 1'b0;
            calc_neg    = 1'b0;
        end
    endtask

    task automatic flag_error(input logic [1:0] code);
        if (calc_status == ST_OK) begin
            calc_status = code;
        end
    endtask

    task automatic evaluate_char(input logic [CHAR_W-1:0] c, input logic l,
                                 output logic has_result, output result_t res);
        has_result = 1'b0;
        res = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            calc_accum  = calc_accum * 10 + (c - CHAR_ZERO);
            calc_in_num = 1'b1;
        end else begin
            fold_number();
            if (c == CHAR_PLUS) begin
                calc_neg = 1'b0;
            end else if (c == CHAR_MINUS) begin
                calc_neg = 1'b1;
            end else if (c == CHAR_OPEN) begin
                if (calc_level < STACK_DEPTH) begin
                    calc_saved_sum[calc_level] = calc_sum;
                    calc_saved_neg[calc_level] = calc_neg;
                    calc_level++;
                end else begin
                    flag_error(ST_OVERFLOW);
                end
                calc_sum = '0;
                calc_neg = 1'b0;
            end else if (c == CHAR_CLOSE) begin
                if (calc_level > 0 && calc_level <= STACK_DEPTH) begin
                    calc_level--;
                    calc_sum = calc_saved_neg[calc_level] ?
                               calc_saved_sum[calc_level] - calc_sum :
                               calc_saved_sum[calc_level] + calc_sum;
                end else begin
                    flag_error(ST_UNMATCHED);
                end
            end
        end
        if (l) begin
            fold_number();
            if (calc_level > 0) begin
                flag_error(ST_UNCLOSED);
            end
            has_result = 1'b1;
            res.value  = calc_sum;
            res.status = calc_status;
            clear_calc();
        end
    endtask

    function automatic bit is_meaningful(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_PLUS || c == CHAR_MINUS ||
               c == CHAR_OPEN || c == CHAR_CLOSE;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic l,
                             input logic use_typed, input result_t typed_res);
        int      gap;
        logic    has_result;
        result_t res;
        gap = source_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        evaluate_char(c, l, has_result, res);
        if (has_result) begin
            pending_results.insert(pending_results.size(), use_typed ? typed_res : res);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic add_char(input logic [CHAR_W-1:0] c);
        expr_text.insert(expr_text.size(), c);
    endtask

    task automatic push_term();
        int n_digits;
        case ($urandom_range(0, 3))
            1: add_char(CHAR_PLUS);
            2: add_char(CHAR_MINUS);
            3: begin
                add_char(CHAR_MINUS);
                add_char(CHAR_MINUS);
            end
            default: ;
        endcase
        n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (n_digits) add_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Mostly balanced expressions with random content; the rest are left
    // unclosed, carry a stray close or are plain noise; some open near or past the stack depth.
    task automatic compose_expression();
        int style;
        int depth;
        int deep_opens;
        expr_text.delete();
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
        end else begin
            depth = 0;
            if ($urandom_range(0, 11) == 0) begin
                deep_opens = $urandom_range(14, STACK_DEPTH + 3);
                repeat (deep_opens) add_char(CHAR_OPEN);
                depth = deep_opens;
            end
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        if (depth < 6) begin
                            if ($urandom_range(0, 1) == 1) begin
                                add_char($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
                            end
                            add_char(CHAR_OPEN);
                            depth++;
                        end else begin
                            push_term();
                        end
                    end
                    2, 3: begin
                        if (depth > 0) begin
                            add_char(CHAR_CLOSE);
                            depth--;
                        end else begin
                            push_term();
                        end
                    end
                    default: push_term();
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    add_char($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(0, 255)));
                end
            end
            if (style != 1) begin
                repeat (depth) add_char(CHAR_CLOSE);
            end
            if (style == 2) begin
                expr_text.insert($urandom_range(0, expr_text.size()), CHAR_CLOSE);
            end
        end
    endtask

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Unexpected result beat: value %0d status %0d",
                                 $signed(m_tdata), m_tuser);
                    end
                end else begin
                    result_t want;
                    want = pending_results.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (m_tdata !== want.value || m_tuser !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("Result mismatch: expected value %0d status %0d, got %0d %0d",
                                     $signed(want.value), want.status,
                                     $signed(m_tdata), m_tuser);
                        end
                    end
                end
                result_wait = sink_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 15) == 0) begin
                    sink_burst = !sink_burst;
                end
            end else if (result_wait > 0) begin
                result_wait--;
            end
            m_tready <= (result_wait == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a beat", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int leftover;
        aclk     = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        clear_calc();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                send_char(directed_rows[i].code,
                          directed_rows[i].last && k == directed_rows[i].reps - 1,
                          directed_rows[i].typed,
                          '{directed_rows[i].value, directed_rows[i].status});
            end
            if (directed_rows[i].last) begin
                expressions++;
            end
        end
        wait_for_drain();

        while (meaningful_sent < RANDOM_CHARS) begin
            compose_expression();
            if ($urandom_range(0, 3) == 0) begin
                source_burst = !source_burst;
            end
            foreach (expr_text[i]) begin
                send_char(expr_text[i], i == expr_text.size() - 1, 1'b0, '0);
                if (is_meaningful(expr_text[i])) begin
                    meaningful_sent++;
                end
            end
            expressions++;
            if (!drained_once && meaningful_sent > RANDOM_CHARS / 2) begin
                wait_for_drain();
                drained_once = 1'b1;
            end
        end

        wait_for_drain();
        repeat (8) @(posedge aclk);
        leftover = pending_results.size();
        if (leftover != 0) begin
            $display("%0d expected results never arrived", leftover);
        end
        $display("Evaluated %0d expressions, %0d results checked, %0d mismatches.",
                 expressions, results_checked, mismatch_count);
        $display("Status mix: ok %0d, overflow %0d, unmatched close %0d, unclosed open %0d.",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW],
                 status_seen[ST_UNMATCHED], status_seen[ST_UNCLOSED]);
        if (mismatch_count == 0 && leftover == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
